FILE: hdl/kscd_pkg.sv
package kscd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned HDR_WORDS  = 5;
  localparam int unsigned HDR_BYTES  = 20;
  localparam int unsigned TAB_DEPTH  = 256;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ERR_W      = 3;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned CFG_ADDR_W = 1;

  localparam logic [WORD_W-1:0] HDR_PREFIX = 32'h0000_0010;

  // error_code, plain_byte, key, body_len, seed, extra_word
  localparam int unsigned OUT_FIELDS_W = ERR_W + 2*BYTE_W + 3*WORD_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_HDR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BODY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
  localparam logic [ERR_W-1:0] ERR_SHORT = 3'd1;
  localparam logic [ERR_W-1:0] ERR_MAGIC = 3'd2;
  localparam logic [ERR_W-1:0] ERR_SIZE  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_EARLY = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_FILE_LEN = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAGIC    = 1'd1;

  typedef logic [BYTE_W-1:0] byte_tab_t [TAB_DEPTH];

  localparam byte_tab_t PERM_TAB = '{
    8'h37, 8'h16, 8'h3f, 8'h51, 8'h7a, 8'h59, 8'h3a, 8'h52, 8'h82, 8'h2c, 8'hdb, 8'hb5,
    8'h2f, 8'h4d, 8'h3e, 8'hb6, 8'h3b, 8'h25, 8'h43, 8'hfd, 8'hfa, 8'h1e, 8'h31, 8'h2e,
    8'hd9, 8'h88, 8'h86, 8'h4e, 8'ha7, 8'h93, 8'ha9, 8'ha6, 8'h5a, 8'h95, 8'h1c, 8'h3d,
    8'hb4, 8'h63, 8'h55, 8'h4b, 8'hba, 8'hcc, 8'hec, 8'h10, 8'hcd, 8'hd3, 8'h3c, 8'hef,
    8'h29, 8'ha0, 8'ha4, 8'he2, 8'h48, 8'h41, 8'h64, 8'h44, 8'h4c, 8'h56, 8'hdf, 8'h23,
    8'hcf, 8'had, 8'h87, 8'h0f, 8'h61, 8'h46, 8'h45, 8'h96, 8'hb0, 8'h00, 8'hb9, 8'h74,
    8'h33, 8'hab, 8'hde, 8'h75, 8'h53, 8'h68, 8'h9a, 8'h99, 8'h0c, 8'h8e, 8'h22, 8'h1a,
    8'h5c, 8'h0d, 8'h6f, 8'h6c, 8'h2b, 8'hf8, 8'h13, 8'hc0, 8'h24, 8'h8a, 8'h80, 8'h89,
    8'h0a, 8'hb3, 8'h81, 8'h85, 8'hf3, 8'h98, 8'he7, 8'h78, 8'h49, 8'he1, 8'h2a, 8'hf7,
    8'hae, 8'h11, 8'h27, 8'h01, 8'h5f, 8'h35, 8'h76, 8'hdd, 8'ha3, 8'haf, 8'h50, 8'he6,
    8'h8b, 8'h7e, 8'h91, 8'h57, 8'hc1, 8'hb8, 8'hf9, 8'h73, 8'h4f, 8'h58, 8'hbf, 8'h05,
    8'h15, 8'he0, 8'h92, 8'h36, 8'hca, 8'h8c, 8'h54, 8'h47, 8'h7d, 8'h7b, 8'hf1, 8'h79,
    8'hed, 8'h94, 8'h9d, 8'hc9, 8'hfb, 8'h6b, 8'hc2, 8'h42, 8'h09, 8'h66, 8'hf5, 8'hd2,
    8'hfc, 8'hf2, 8'h20, 8'h19, 8'h1b, 8'h39, 8'he8, 8'h5e, 8'h70, 8'ha1, 8'h7f, 8'h9b,
    8'h26, 8'h62, 8'hf0, 8'hbe, 8'h32, 8'hc8, 8'h4a, 8'hb2, 8'hd4, 8'ha8, 8'hb7, 8'heb,
    8'h65, 8'h90, 8'h17, 8'hce, 8'hd0, 8'h9c, 8'h12, 8'hd8, 8'haa, 8'h04, 8'h8f, 8'h5b,
    8'h2d, 8'hb1, 8'h6a, 8'h07, 8'h6e, 8'h08, 8'h77, 8'hc3, 8'h18, 8'hbd, 8'h9f, 8'ha2,
    8'hf4, 8'h97, 8'hf6, 8'hc5, 8'h1d, 8'h71, 8'hac, 8'h14, 8'hea, 8'h69, 8'h34, 8'h60,
    8'hcb, 8'ha5, 8'he9, 8'hee, 8'h9e, 8'h06, 8'hc6, 8'he5, 8'hff, 8'h6d, 8'hc4, 8'h8d,
    8'he3, 8'hd1, 8'hbb, 8'h38, 8'hc7, 8'h03, 8'h30, 8'h40, 8'hda, 8'hd6, 8'h5d, 8'hdc,
    8'h0e, 8'hbc, 8'h67, 8'h21, 8'h1f, 8'he4, 8'h02, 8'hd7, 8'h84, 8'h7c, 8'h72, 8'h28,
    8'hfe, 8'h83, 8'h0b, 8'hd5
  };

  function automatic byte_tab_t build_inv_tab(byte_tab_t perm);
    byte_tab_t inv;
    for (int j = 0; j < TAB_DEPTH; j++) begin
      inv[perm[j]] = BYTE_W'(j);
    end
    return inv;
  endfunction

  localparam byte_tab_t INV_TAB = build_inv_tab(PERM_TAB);

endpackage

FILE: hdl/keyed_substitution_container_decoder_top.sv
// channel   dir  tdata                                          tuser  tlast
// in_       in   in_byte                                        -      in_last
// out_      out  error_code, plain_byte, key, body_len,         kind   body_last
//                seed, extra_word (lowest bit up, zero padded)
// cfg_      in   write enable, register index, 32-bit data      -      -
//
// one beat per cycle when not stalled; a result appears the cycle after its beat
// the inverse table is a registered rom read, fed by byte minus key
// a result waiting for out_tready holds in_tready low until it is taken
// rst_n is synchronous; only control state and registers are cleared
module keyed_substitution_container_decoder_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [kscd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [kscd_pkg::WORD_W-1:0]        cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kscd_pkg::BYTE_W-1:0]        in_tdata,   // in_byte
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // error_code, plain_byte, key, body_len, seed, extra_word, zero pad
  output logic [kscd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [kscd_pkg::KIND_W-1:0]        out_tuser,  // kind
  output logic                               out_tlast
);
  import kscd_pkg::*;

  localparam logic [PHASE_W-1:0] PH_HDR  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BODY = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SKIP = 2'd2;

  logic [WORD_W-1:0]  file_len_r;
  logic [WORD_W-1:0]  magic_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]   hcnt_r, hcnt_nxt;
  logic [BYTE_W-1:0]  key_r, key_nxt;
  logic [WORD_W-1:0]  brem_r, brem_nxt;
  logic [WORD_W-1:0]  hw_r [HDR_WORDS];

  logic               out_valid_r;
  logic [KIND_W-1:0]  kind_r;
  logic [ERR_W-1:0]   err_r;
  logic [BYTE_W-1:0]  plain_r;
  logic               last_r;
  logic [BYTE_W-1:0]  okey_r;
  logic [WORD_W-1:0]  size_r;
  logic [WORD_W-1:0]  seed_r;
  logic [WORD_W-1:0]  extra_r;

  logic               acc;
  logic               hdr_done;
  logic               size_fail;
  logic [WORD_W-1:0]  seed_w;
  logic [BYTE_W-1:0]  tab_idx;
  logic               res_v;
  logic [KIND_W-1:0]  res_kind;
  logic [ERR_W-1:0]   res_err;
  logic               res_last;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign hdr_done  = (hcnt_r == CNT_W'(HDR_BYTES - 1));
  assign seed_w    = {in_tdata, hw_r[4][WORD_W-BYTE_W-1:0]};
  assign size_fail = (hw_r[2] == '0) ||
                     (({1'b0, hw_r[2]} + (WORD_W+1)'(HDR_BYTES)) > {1'b0, file_len_r});
  assign tab_idx   = in_tdata - key_r;

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    key_nxt   = key_r;
    brem_nxt  = brem_r;
    res_v     = 1'b0;
    res_kind  = KIND_HDR;
    res_err   = ERR_NONE;
    res_last  = 1'b0;
    unique case (phase_r)
      PH_HDR: begin
        hcnt_nxt = hcnt_r + 1'b1;
        if (!hdr_done) begin
          if (in_tlast) begin
            res_v    = 1'b1;
            res_kind = KIND_ERR;
            res_err  = ERR_SHORT;
          end
        end else begin
          res_v = 1'b1;
          if (file_len_r < WORD_W'(HDR_BYTES)) begin
            res_kind  = KIND_ERR;
            res_err   = ERR_SHORT;
            phase_nxt = PH_SKIP;
          end else if (hw_r[0] != HDR_PREFIX || hw_r[1] != magic_r) begin
            res_kind  = KIND_ERR;
            res_err   = ERR_MAGIC;
            phase_nxt = PH_SKIP;
          end else if (size_fail) begin
            res_kind  = KIND_ERR;
            res_err   = ERR_SIZE;
            phase_nxt = PH_SKIP;
          end else if (in_tlast) begin
            res_kind = KIND_ERR;
            res_err  = ERR_EARLY;
          end else begin
            key_nxt   = seed_w[2*BYTE_W-1:BYTE_W];
            brem_nxt  = hw_r[2];
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (brem_r == '0) begin
          phase_nxt = PH_SKIP;
        end else if (in_tlast && brem_r != WORD_W'(1)) begin
          res_v    = 1'b1;
          res_kind = KIND_ERR;
          res_err  = ERR_EARLY;
        end else begin
          res_v    = 1'b1;
          res_kind = KIND_BODY;
          res_last = (brem_r == WORD_W'(1));
          brem_nxt = brem_r - 1'b1;
          if (brem_r == WORD_W'(1)) begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      default: begin
      end
    endcase
    // every file end rearms for a new header
    if (in_tlast) begin
      phase_nxt = PH_HDR;
      hcnt_nxt  = '0;
      brem_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_len_r <= '0;
      magic_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FILE_LEN: file_len_r <= cfg_wdata;
        REG_MAGIC:    magic_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      hcnt_r  <= '0;
      key_r   <= '0;
      brem_r  <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      key_r   <= key_nxt;
      brem_r  <= brem_nxt;
    end
  end

  // header byte store, little-endian within each word
  always_ff @(posedge clk) begin
    if (acc && phase_r == PH_HDR) begin
      hw_r[hcnt_r[CNT_W-1:2]][{hcnt_r[1:0], 3'b000} +: BYTE_W] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= acc && res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      kind_r  <= res_kind;
      err_r   <= res_err;
      last_r  <= res_last;
      plain_r <= (res_kind == KIND_BODY) ? INV_TAB[tab_idx] : '0;
      if (res_kind == KIND_HDR) begin
        okey_r  <= seed_w[2*BYTE_W-1:BYTE_W];
        size_r  <= hw_r[2];
        seed_r  <= seed_w;
        extra_r <= hw_r[3];
      end else begin
        okey_r  <= '0;
        size_r  <= '0;
        seed_r  <= '0;
        extra_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                       extra_r, seed_r, size_r, okey_r, plain_r, err_r};

endmodule
